// File: hw/rtl/gtg_pkg.sv
package gtg_pkg;

  // stream payload layout
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned KindW    = 2;

  // item kinds carried in tuser
  typedef enum logic [KindW-1:0] {
    REQ_GOAL = 2'd0,
    REQ_SCAN = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  // result status carried in tuser
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_REACHED = 2'd1,
    ST_AVOID   = 2'd2,
    ST_DRIVING = 2'd3
  } drive_status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GOAL_TOL    = 3'd0,
    CFG_OBST_DIST   = 3'd1,
    CFG_MAX_LIN     = 3'd2,
    CFG_MAX_TURN    = 3'd3,
    CFG_AVOID_TURN  = 3'd4,
    CFG_LIN_GAIN    = 3'd5,
    CFG_ANG_GAIN    = 3'd6,
    CFG_SCAN_POINTS = 3'd7
  } cfg_idx_e;

  // datapath widths
  localparam int unsigned XyW   = 28;  // cordic x/y, signed, covers gain growth
  localparam int unsigned MulAW = 28;
  localparam int unsigned MulBW = 26;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned DistW = 26;
  localparam int unsigned PtsW  = 11;

  // fixed-point constants
  localparam logic [15:0] InvKQ16  = 16'd39797;
  localparam logic [17:0] PiQ16    = 18'd205887;
  localparam logic [15:0] HalfTurn = 16'h8000;
  localparam logic [14:0] TurnLim  = 15'h7fff;

  // floor(p / 360) as (p * WinRecip) >> WinShift, exact for p below 2048
  localparam logic [11:0] WinRecip = 12'd2913;
  localparam int unsigned WinShift = 20;
  localparam logic [4:0]  WinStep  = 5'd30;

  // atan(2^-i) in 16-bit binary angle
  function automatic logic [15:0] gtg_atan(input logic [4:0] idx);
    logic [15:0] a;
    case (idx)
      5'd0:    a = 16'd8192;
      5'd1:    a = 16'd4836;
      5'd2:    a = 16'd2555;
      5'd3:    a = 16'd1297;
      5'd4:    a = 16'd651;
      5'd5:    a = 16'd326;
      5'd6:    a = 16'd163;
      5'd7:    a = 16'd81;
      5'd8:    a = 16'd41;
      5'd9:    a = 16'd20;
      5'd10:   a = 16'd10;
      5'd11:   a = 16'd5;
      5'd12:   a = 16'd3;
      5'd13:   a = 16'd1;
      5'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/go_to_goal_controller_with_obstacle_stop.sv
// a goal beat and a scan beat give no result; a tick runs S_PRE, S_CORDIC, S_MULX, S_DIST,
// S_DECIDE, S_LIN, S_TURN1, S_TURN2 and S_EMIT to the result (S_DECIDE goes straight to S_EMIT when
// the goal is reached or an obstacle is seen; a tick with no goal goes straight to S_EMIT)
// one beat at a time; the iterative cordic and the single shared multiplier set the tick time
// reset (rst_ni low, async): configuration registers take their default values, no goal, no scan,
// no obstacle mark, output empty
module go_to_goal_controller_with_obstacle_stop
  import gtg_pkg::*;
#(
  parameter int unsigned MAX_SCAN_POINTS = 1024,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // pos_x[23:0], pos_y[47:24], heading[63:48], pose_ok[64], sample_index[74:65],
  // sample_range[90:75], sample_finite[91], zero pad[95:92]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // req_type[1:0]
  input  logic [KindW-1:0]    s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  // output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // linear_speed[15:0], turn_rate[31:16]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // drive_status[1:0]
  output logic [1:0]          m_axis_tuser_o
);

  localparam int unsigned StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);
  localparam logic [12:0] MaxPts = 13'(MAX_SCAN_POINTS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PRE,
    S_CORDIC,
    S_MULX,
    S_DIST,
    S_DECIDE,
    S_LIN,
    S_TURN1,
    S_TURN2,
    S_EMIT
  } state_e;

  // configuration registers
  logic [15:0]        goal_tol_q, obst_dist_q, max_lin_q, max_turn_q;
  logic signed [15:0] avoid_turn_q;
  logic [11:0]        lin_gain_q, ang_gain_q;
  logic [PtsW-1:0]    scan_points_q;

  // controller state
  state_e             state_q;
  logic signed [23:0] target_x_q, target_y_q;
  logic               target_valid_q, scan_valid_q, obst_seen_q, obst_running_q;

  // beat payload captured on accept
  logic [15:0]        heading_q, range_q;
  logic [9:0]         idx_q;
  logic               finite_q, last_q;

  // shared datapath
  logic signed [XyW-1:0] x_q, y_q;
  logic [15:0]           z_q;
  logic [StepW-1:0]      step_q;
  logic [ProdW-1:0]      prod_q;
  logic [DistW-1:0]      dist_q;
  logic signed [15:0]    err_q;
  logic [15:0]           mag_q;
  logic [15:0]           lin_q;
  logic [2:0]            quot_q;

  // pending result and output register
  logic [15:0]        res_lin_q;
  logic signed [15:0] res_turn_q;
  drive_status_e      res_status_q;
  logic               out_valid_q;
  logic [15:0]        out_lin_q;
  logic [15:0]        out_turn_q;
  drive_status_e      out_status_q;

  // input field slices
  logic signed [23:0] in_pos_x, in_pos_y;
  logic [15:0]        in_heading, in_range;
  logic               in_pose_ok, in_finite;
  logic [9:0]         in_idx;
  logic               accept;

  assign in_pos_x   = s_axis_tdata_i[23:0];
  assign in_pos_y   = s_axis_tdata_i[47:24];
  assign in_heading = s_axis_tdata_i[63:48];
  assign in_pose_ok = s_axis_tdata_i[64];
  assign in_idx     = s_axis_tdata_i[74:65];
  assign in_range   = s_axis_tdata_i[90:75];
  assign in_finite  = s_axis_tdata_i[91];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_tol_q    <= 16'd102;
      obst_dist_q   <= 16'd307;
      max_lin_q     <= 16'd205;
      max_turn_q    <= 16'd512;
      avoid_turn_q  <= 16'sd512;
      lin_gain_q    <= 12'd128;
      ang_gain_q    <= 12'd512;
      scan_points_q <= 11'd360;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GOAL_TOL:    goal_tol_q    <= cfg_data_i;
        CFG_OBST_DIST:   obst_dist_q   <= cfg_data_i;
        CFG_MAX_LIN:     max_lin_q     <= cfg_data_i;
        CFG_MAX_TURN:    max_turn_q    <= cfg_data_i;
        CFG_AVOID_TURN:  avoid_turn_q  <= cfg_data_i;
        CFG_LIN_GAIN:    lin_gain_q    <= cfg_data_i[11:0];
        CFG_ANG_GAIN:    ang_gain_q    <= cfg_data_i[11:0];
        CFG_SCAN_POINTS: scan_points_q <= cfg_data_i[PtsW-1:0];
        default: ;
      endcase
    end
  end

  // scan window: effective point count and its registered share of 360
  logic [PtsW-1:0] pts_eff;
  logic [22:0]     win_prod;
  logic [9:0]      win_half;
  logic [PtsW:0]   win_lo, win_hi;
  logic            win_hit;

  always_comb begin
    pts_eff  = (13'(scan_points_q) < MaxPts) ? scan_points_q : PtsW'(MaxPts);
    win_prod = 23'(pts_eff) * 23'(WinRecip);
    win_half = 10'(quot_q) * 10'(WinStep);
    win_lo   = 12'(pts_eff >> 1) - 12'(win_half);
    win_hi   = 12'(pts_eff >> 1) + 12'(win_half);
    win_hit  = (11'(idx_q) < pts_eff) && (12'(idx_q) >= win_lo) && (12'(idx_q) <= win_hi)
               && finite_q && (range_q < obst_dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= 3'd1;
    end else begin
      quot_q <= win_prod[22:WinShift];
    end
  end

  // cordic step on the shared shifter and adders
  logic signed [XyW-1:0] xs, ys;
  logic [15:0]           atan_v;

  always_comb begin
    xs     = x_q >>> step_q;
    ys     = y_q >>> step_q;
    atan_v = gtg_atan(5'(step_q));
  end

  // shared multiplier, operands picked by state
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod_d;

  always_comb begin
    case (state_q)
      S_MULX: begin
        mul_a = x_q[XyW-1] ? '0 : MulAW'(x_q[XyW-2:0]);
        mul_b = MulBW'(InvKQ16);
      end
      S_DECIDE: begin
        mul_a = MulAW'(lin_gain_q);
        mul_b = dist_q;
      end
      S_LIN: begin
        mul_a = MulAW'(ang_gain_q);
        mul_b = MulBW'(mag_q);
      end
      S_TURN1: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = MulBW'(PiQ16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // result shaping
  logic [44:0]        dist_rnd;
  logic [29:0]        lin_full;
  logic [46:0]        turn_rnd;
  logic [14:0]        turn_lim;
  logic [14:0]        turn_mag;
  logic signed [15:0] turn_val;

  always_comb begin
    dist_rnd = 45'(prod_q[42:0]) + 45'd32768;
    lin_full = prod_q[37:8];
    turn_rnd = 47'(prod_q[45:0]) + (47'd1 << 28);
    turn_lim = (max_turn_q < 16'(TurnLim)) ? max_turn_q[14:0] : TurnLim;
    turn_mag = (turn_rnd[46:29] > 18'(turn_lim)) ? turn_lim : turn_rnd[43:29];
    turn_val = err_q[15] ? -$signed({1'b0, turn_mag}) : $signed({1'b0, turn_mag});
  end

  // sequencer, state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      target_valid_q <= 1'b0;
      scan_valid_q   <= 1'b0;
      obst_seen_q    <= 1'b0;
      obst_running_q <= 1'b0;
      out_valid_q    <= 1'b0;
      step_q         <= '0;
    end else begin
      if (state_q != S_EMIT && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_type_e'(s_axis_tuser_i))
              REQ_GOAL: begin
                target_valid_q <= 1'b1;
              end
              REQ_SCAN: begin
                state_q <= S_SCAN;
              end
              REQ_TICK: begin
                if (!target_valid_q) begin
                  res_lin_q    <= '0;
                  res_turn_q   <= '0;
                  res_status_q <= ST_IDLE;
                  state_q      <= S_EMIT;
                end else if (in_pose_ok) begin
                  x_q     <= XyW'(target_x_q) - XyW'(in_pos_x);
                  y_q     <= XyW'(target_y_q) - XyW'(in_pos_y);
                  z_q     <= '0;
                  state_q <= S_PRE;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (last_q) begin
            obst_seen_q    <= obst_running_q || win_hit;
            obst_running_q <= 1'b0;
            scan_valid_q   <= 1'b1;
          end else if (win_hit) begin
            obst_running_q <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_PRE: begin
          // fold the left half plane into the right one
          if (x_q < 0) begin
            x_q <= -x_q;
            y_q <= -y_q;
            z_q <= HalfTurn;
          end
          step_q  <= '0;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (y_q < 0) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_v;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_v;
          end
          step_q <= step_q + StepW'(1);
          if (step_q == LastStep) begin
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          state_q <= S_DIST;
        end
        S_DIST: begin
          dist_q  <= dist_rnd[16+DistW-1:16];
          err_q   <= z_q - heading_q;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          mag_q <= err_q[15] ? 16'(-err_q) : err_q;
          if (dist_q < DistW'(goal_tol_q)) begin
            target_valid_q <= 1'b0;
            res_lin_q      <= '0;
            res_turn_q     <= '0;
            res_status_q   <= ST_REACHED;
            state_q        <= S_EMIT;
          end else if (scan_valid_q && obst_seen_q) begin
            res_lin_q    <= '0;
            res_turn_q   <= avoid_turn_q;
            res_status_q <= ST_AVOID;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_LIN;
          end
        end
        S_LIN: begin
          lin_q   <= (lin_full > 30'(max_lin_q)) ? max_lin_q : lin_full[15:0];
          state_q <= S_TURN1;
        end
        S_TURN1: begin
          state_q <= S_TURN2;
        end
        S_TURN2: begin
          res_lin_q    <= lin_q;
          res_turn_q   <= turn_val;
          res_status_q <= ST_DRIVING;
          state_q      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q  <= 1'b1;
            out_lin_q    <= res_lin_q;
            out_turn_q   <= res_turn_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      prod_q <= prod_d;
    end
  end

  // payload capture on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      heading_q <= in_heading;
      idx_q     <= in_idx;
      range_q   <= in_range;
      finite_q  <= in_finite;
      last_q    <= s_axis_tlast_i;
      if (req_type_e'(s_axis_tuser_i) == REQ_GOAL) begin
        target_x_q <= in_pos_x;
        target_y_q <= in_pos_y;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_turn_q, out_lin_q};
  assign m_axis_tuser_o  = out_status_q;

  // a new result only comes out of the emit state
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_EMIT))
    else $error("result appeared outside the emit state");

  // a reached result never leaves a goal behind
  a_reached_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_status_q == ST_REACHED) |-> !target_valid_q)
    else $error("goal still valid after reached");

  // the last sample of a scan closes the running mark
  a_scan_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && last_q) |=> (!obst_running_q && scan_valid_q))
    else $error("scan latch did not close");

  // the step counter stays inside the cordic schedule
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORDIC) |-> (step_q <= LastStep))
    else $error("cordic step out of range");

endmodule
